// ===== rtl/core/lru_pr_pkg.sv =====
// ----------------------------------------------------------------------------
// lru_pr_pkg
// Shared types and constants for the lru page replacement engine.
// ----------------------------------------------------------------------------
package lru_pr_pkg;

   localparam int COUNT_BITS       = 32;
   localparam int CFG_BITS         = 5;
   localparam int FRAME_INDEX_BITS = 4;

   localparam logic [CFG_BITS-1:0]   CFG_RESET = 5'd16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // flags that travel with the probe from cell to cell
   typedef struct packed {
      logic valid;
      logic found;
      logic best_valid;
   } probe_ctl_type;

   // write-back command broadcast to all cells
   typedef struct packed {
      logic en;
      logic fill;
   } wr_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMMIT
   } state_type;

endpackage

// ===== rtl/core/lru_pr_cell.sv =====
// ----------------------------------------------------------------------------
// lru_pr_cell
// One page frame: holds valid, page and stamp, updates the passing probe
// with its match and minimum-stamp results, and takes write-back commands.
// ----------------------------------------------------------------------------
module lru_pr_cell #(
   parameter int INDEX      = 0,
   parameter int PAGE_BITS  = 20,
   parameter int STAMP_BITS = 32,
   parameter int IDX_BITS   = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       active,
   input  lru_pr_pkg::probe_ctl_type  prb_ctl_in,
   input  logic [PAGE_BITS-1:0]       prb_page_in,
   input  logic [IDX_BITS-1:0]        prb_hit_slot_in,
   input  logic [STAMP_BITS-1:0]      prb_best_stamp_in,
   input  logic [IDX_BITS-1:0]        prb_best_slot_in,
   input  logic [PAGE_BITS-1:0]       prb_best_page_in,
   output lru_pr_pkg::probe_ctl_type  prb_ctl_out,
   output logic [PAGE_BITS-1:0]       prb_page_out,
   output logic [IDX_BITS-1:0]        prb_hit_slot_out,
   output logic [STAMP_BITS-1:0]      prb_best_stamp_out,
   output logic [IDX_BITS-1:0]        prb_best_slot_out,
   output logic [PAGE_BITS-1:0]       prb_best_page_out,
   input  lru_pr_pkg::wr_ctl_type     wr_ctl,
   input  logic [IDX_BITS-1:0]        wr_slot,
   input  logic [PAGE_BITS-1:0]       wr_page,
   input  logic [STAMP_BITS-1:0]      wr_stamp
);

   localparam logic [IDX_BITS-1:0] MY_INDEX = IDX_BITS'(INDEX);

   logic                      valid_ff;
   logic [PAGE_BITS-1:0]      page_ff;
   logic [STAMP_BITS-1:0]     stamp_ff;

   lru_pr_pkg::probe_ctl_type ctl_in, ctl_ff;
   logic [PAGE_BITS-1:0]      page_o_ff;
   logic [IDX_BITS-1:0]       hit_slot_in, hit_slot_ff;
   logic [STAMP_BITS-1:0]     best_stamp_in, best_stamp_ff;
   logic [IDX_BITS-1:0]       best_slot_in, best_slot_ff;
   logic [PAGE_BITS-1:0]      best_page_in, best_page_ff;

   logic match;
   logic take_min;
   logic wr_hit;

   // first match wins, so a lower frame that already matched keeps the hit
   assign match    = active && valid_ff && (page_ff == prb_page_in) && !prb_ctl_in.found;
   // cell zero seeds the minimum; strict compare keeps ties on the lower frame
   assign take_min = active && ((INDEX == 0) || (stamp_ff < prb_best_stamp_in));
   assign wr_hit   = wr_ctl.en && (wr_slot == MY_INDEX);

   always_comb begin
      ctl_in            = prb_ctl_in;
      ctl_in.found      = prb_ctl_in.found | match;
      ctl_in.best_valid = take_min ? valid_ff : prb_ctl_in.best_valid;
      hit_slot_in       = match ? MY_INDEX : prb_hit_slot_in;
      best_stamp_in     = take_min ? stamp_ff : prb_best_stamp_in;
      best_slot_in      = take_min ? MY_INDEX : prb_best_slot_in;
      best_page_in      = take_min ? page_ff : prb_best_page_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         stamp_ff <= '0;
      end else if (wr_hit) begin
         stamp_ff <= wr_stamp;
         if (wr_ctl.fill) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_hit && wr_ctl.fill) begin
         page_ff <= wr_page;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      page_o_ff     <= prb_page_in;
      hit_slot_ff   <= hit_slot_in;
      best_stamp_ff <= best_stamp_in;
      best_slot_ff  <= best_slot_in;
      best_page_ff  <= best_page_in;
   end

   assign prb_ctl_out        = ctl_ff;
   assign prb_page_out       = page_o_ff;
   assign prb_hit_slot_out   = hit_slot_ff;
   assign prb_best_stamp_out = best_stamp_ff;
   assign prb_best_slot_out  = best_slot_ff;
   assign prb_best_page_out  = best_page_ff;

endmodule

// ===== rtl/core/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement engine built as a chain of frame cells.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req_     in         req_valid/req_stall   page_number
//  rsp_     out        rsp_valid/rsp_stall   hit, frame_index, evicted_valid,
//                                            evicted_page, fault_total
//  csr_     in         csr_valid/csr_ready   frames_in_use (write only)
//
//  one reference at a time: the probe walks the FRAMES cells one per cycle,
//  then the end of the chain is captured and committed to the result
//  register, and the next one can be accepted once its result is loaded.
//  reset clears all frames, stamps and counters and sets frames_in_use to 16.
//  a stalled result holds the commit step; req_stall is high while busy.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
   parameter int FRAMES     = 16,
   parameter int PAGE_BITS  = 20,
   parameter int STAMP_BITS = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic [PAGE_BITS-1:0]                        req_page_number,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic                                        rsp_hit,
   output logic [lru_pr_pkg::FRAME_INDEX_BITS-1:0]     rsp_frame_index,
   output logic                                        rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]                        rsp_evicted_page,
   output logic [lru_pr_pkg::COUNT_BITS-1:0]           rsp_fault_total,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [lru_pr_pkg::CFG_BITS-1:0]             csr_frames_in_use
);

   localparam int IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int IXW      = (IDX_BITS > lru_pr_pkg::FRAME_INDEX_BITS) ?
                             IDX_BITS : lru_pr_pkg::FRAME_INDEX_BITS;
   localparam int CW       = (STAMP_BITS > lru_pr_pkg::COUNT_BITS) ?
                             STAMP_BITS : lru_pr_pkg::COUNT_BITS;
   localparam logic [CW-1:0] STAMP_MAX_EXT = CW'({STAMP_BITS{1'b1}});

   // configuration
   logic [lru_pr_pkg::CFG_BITS-1:0] frames_in_use_ff;
   logic [FRAMES-1:0]               cell_active;

   // state machine
   lru_pr_pkg::state_type state_ff, state_in;
   logic                  accept;
   logic                  commit;
   logic                  capture;

   // probe chain taps
   lru_pr_pkg::probe_ctl_type prb_ctl        [0:FRAMES];
   logic [PAGE_BITS-1:0]      prb_page       [0:FRAMES];
   logic [IDX_BITS-1:0]       prb_hit_slot   [0:FRAMES];
   logic [STAMP_BITS-1:0]     prb_best_stamp [0:FRAMES];
   logic [IDX_BITS-1:0]       prb_best_slot  [0:FRAMES];
   logic [PAGE_BITS-1:0]      prb_best_page  [0:FRAMES];
   logic [FRAMES:0]           prb_valid_vec;

   lru_pr_pkg::probe_ctl_type probe_ctl_ff;
   logic [PAGE_BITS-1:0]      probe_page_ff;

   // captured end of chain
   lru_pr_pkg::probe_ctl_type hold_ctl_ff;
   logic [PAGE_BITS-1:0]      hold_page_ff;
   logic [IDX_BITS-1:0]       hold_hit_slot_ff;
   logic [IDX_BITS-1:0]       hold_best_slot_ff;
   logic [PAGE_BITS-1:0]      hold_best_page_ff;

   // counters
   logic [lru_pr_pkg::COUNT_BITS-1:0] ref_count_ff, ref_next;
   logic [lru_pr_pkg::COUNT_BITS-1:0] fault_count_ff, fault_next;
   logic [CW-1:0]                     ref_ext;
   logic [STAMP_BITS-1:0]             stamp_new;

   // write-back broadcast
   lru_pr_pkg::wr_ctl_type wr_ctl_ff;
   logic [IDX_BITS-1:0]    wr_slot_ff;
   logic [PAGE_BITS-1:0]   wr_page_ff;
   logic [STAMP_BITS-1:0]  wr_stamp_ff;

   // commit decision
   logic [IDX_BITS-1:0] commit_slot;
   logic [IXW-1:0]      commit_slot_ext;
   logic                commit_ev_valid;

   // result register
   logic                                    rsp_valid_ff;
   logic                                    rsp_hit_ff;
   logic [lru_pr_pkg::FRAME_INDEX_BITS-1:0] rsp_frame_index_ff;
   logic                                    rsp_evicted_valid_ff;
   logic [PAGE_BITS-1:0]                    rsp_evicted_page_ff;
   logic [lru_pr_pkg::COUNT_BITS-1:0]       rsp_fault_total_ff;

   // ---------------------------------------------------------------------
   // configuration register
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= lru_pr_pkg::CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         frames_in_use_ff <= csr_frames_in_use;
      end
   end

   // frame zero always takes part, counts above FRAMES clip naturally
   for (genvar i = 0; i < FRAMES; i++) begin : g_active
      assign cell_active[i] = (i == 0) || (i < int'(frames_in_use_ff));
   end

   // ---------------------------------------------------------------------
   // state machine
   // ---------------------------------------------------------------------
   assign accept  = req_valid && !req_stall;
   assign capture = (state_ff == lru_pr_pkg::ST_SEARCH) && prb_ctl[FRAMES].valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lru_pr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      commit    = 1'b0;
      case (state_ff)
         lru_pr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = lru_pr_pkg::ST_SEARCH;
            end
         end
         lru_pr_pkg::ST_SEARCH: begin
            if (prb_ctl[FRAMES].valid) begin
               state_in = lru_pr_pkg::ST_COMMIT;
            end
         end
         lru_pr_pkg::ST_COMMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               commit   = 1'b1;
               state_in = lru_pr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lru_pr_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // probe injection and cell chain
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ctl_ff <= '0;
      end else begin
         probe_ctl_ff.valid      <= accept;
         probe_ctl_ff.found      <= 1'b0;
         probe_ctl_ff.best_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         probe_page_ff <= req_page_number;
      end
   end

   assign prb_ctl[0]        = probe_ctl_ff;
   assign prb_page[0]       = probe_page_ff;
   assign prb_hit_slot[0]   = '0;
   assign prb_best_stamp[0] = '0;
   assign prb_best_slot[0]  = '0;
   assign prb_best_page[0]  = '0;

   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      lru_pr_cell #(
         .INDEX      (i),
         .PAGE_BITS  (PAGE_BITS),
         .STAMP_BITS (STAMP_BITS),
         .IDX_BITS   (IDX_BITS)
      ) u_cell (
         .clock              (clock),
         .reset              (reset),
         .active             (cell_active[i]),
         .prb_ctl_in         (prb_ctl[i]),
         .prb_page_in        (prb_page[i]),
         .prb_hit_slot_in    (prb_hit_slot[i]),
         .prb_best_stamp_in  (prb_best_stamp[i]),
         .prb_best_slot_in   (prb_best_slot[i]),
         .prb_best_page_in   (prb_best_page[i]),
         .prb_ctl_out        (prb_ctl[i+1]),
         .prb_page_out       (prb_page[i+1]),
         .prb_hit_slot_out   (prb_hit_slot[i+1]),
         .prb_best_stamp_out (prb_best_stamp[i+1]),
         .prb_best_slot_out  (prb_best_slot[i+1]),
         .prb_best_page_out  (prb_best_page[i+1]),
         .wr_ctl             (wr_ctl_ff),
         .wr_slot            (wr_slot_ff),
         .wr_page            (wr_page_ff),
         .wr_stamp           (wr_stamp_ff)
      );
   end

   for (genvar i = 0; i <= FRAMES; i++) begin : g_vvec
      assign prb_valid_vec[i] = prb_ctl[i].valid;
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         hold_ctl_ff       <= prb_ctl[FRAMES];
         hold_page_ff      <= prb_page[FRAMES];
         hold_hit_slot_ff  <= prb_hit_slot[FRAMES];
         hold_best_slot_ff <= prb_best_slot[FRAMES];
         hold_best_page_ff <= prb_best_page[FRAMES];
      end
   end

   // ---------------------------------------------------------------------
   // commit: counters, write-back, result
   // ---------------------------------------------------------------------
   assign ref_next   = (ref_count_ff == lru_pr_pkg::COUNT_MAX) ?
                       ref_count_ff : ref_count_ff + 1'b1;
   assign fault_next = (!hold_ctl_ff.found && (fault_count_ff != lru_pr_pkg::COUNT_MAX)) ?
                       fault_count_ff + 1'b1 : fault_count_ff;
   assign ref_ext    = CW'(ref_next);
   assign stamp_new  = (ref_ext > STAMP_MAX_EXT) ? STAMP_MAX_EXT[STAMP_BITS-1:0] :
                       ref_ext[STAMP_BITS-1:0];

   assign commit_slot     = hold_ctl_ff.found ? hold_hit_slot_ff : hold_best_slot_ff;
   assign commit_slot_ext = IXW'(commit_slot);
   assign commit_ev_valid = !hold_ctl_ff.found && hold_ctl_ff.best_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_count_ff   <= '0;
         fault_count_ff <= '0;
         wr_ctl_ff      <= '0;
      end else begin
         wr_ctl_ff.en   <= commit;
         wr_ctl_ff.fill <= !hold_ctl_ff.found;
         if (commit) begin
            ref_count_ff   <= ref_next;
            fault_count_ff <= fault_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         wr_slot_ff  <= commit_slot;
         wr_page_ff  <= hold_page_ff;
         wr_stamp_ff <= stamp_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_hit_ff           <= hold_ctl_ff.found;
         rsp_frame_index_ff   <= commit_slot_ext[lru_pr_pkg::FRAME_INDEX_BITS-1:0];
         rsp_evicted_valid_ff <= commit_ev_valid;
         rsp_evicted_page_ff  <= commit_ev_valid ? hold_best_page_ff : '0;
         rsp_fault_total_ff   <= fault_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_index_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_page  = rsp_evicted_page_ff;
   assign rsp_fault_total   = rsp_fault_total_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_one_probe: assert property (@(posedge clock) disable iff (reset)
      $countones(prb_valid_vec) <= 1)
      else $error("more than one probe in the cell chain");

   a_end_in_search: assert property (@(posedge clock) disable iff (reset)
      prb_ctl[FRAMES].valid |-> state_ff == lru_pr_pkg::ST_SEARCH)
      else $error("probe left the chain outside the search state");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lru_pr_pkg::ST_COMMIT) && rsp_valid_ff && rsp_stall
      |=> state_ff == lru_pr_pkg::ST_COMMIT)
      else $error("commit overwrote a result that was not taken");

   a_wb_idle: assert property (@(posedge clock) disable iff (reset)
      wr_ctl_ff.en |-> (state_ff == lru_pr_pkg::ST_IDLE) && (prb_valid_vec == '0))
      else $error("write-back overlaps a probe");

endmodule
